/* rtl/iphb_pkg.sv */
package iphb_pkg;

  // header geometry
  localparam int unsigned HdrBytes = 20;
  localparam int unsigned HdrBits  = HdrBytes * 8;
  localparam int unsigned IdxW     = 5;

  localparam logic [IdxW-1:0] IdxFirst = IdxW'(0);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(HdrBytes - 1);

  // fixed header fields
  localparam logic [7:0]  VerIhl    = 8'h45;
  localparam logic [7:0]  Tos       = 8'h00;
  localparam logic [15:0] FlagsFrag = 16'h4000;
  localparam logic [7:0]  Ttl       = 8'h40;

  typedef logic [HdrBits-1:0] hdr_t;

endpackage

/* rtl/iphb_hdr_fmt.sv */
module iphb_hdr_fmt (
  input  logic [15:0]     total_length_i,
  input  logic [31:0]     source_address_i,
  input  logic [31:0]     destination_address_i,
  input  logic [7:0]      protocol_number_i,
  input  logic [15:0]     ident_i,
  output iphb_pkg::hdr_t  hdr_o
);
  import iphb_pkg::*;

  logic [15:0] w_ver_tos;
  logic [15:0] w_ttl_proto;
  logic [19:0] acc;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;

  // ones'-complement sum of the nine nonzero header words
  assign w_ver_tos   = {VerIhl, Tos};
  assign w_ttl_proto = {Ttl, protocol_number_i};

  assign acc = 20'(w_ver_tos) + 20'(total_length_i) + 20'(ident_i) + 20'(FlagsFrag)
             + 20'(w_ttl_proto)
             + 20'(source_address_i[31:16]) + 20'(source_address_i[15:0])
             + 20'(destination_address_i[31:16]) + 20'(destination_address_i[15:0]);

  // end-around carry, twice covers every case
  assign fold1 = 17'(acc[15:0]) + 17'(acc[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign csum  = ~fold2;

  // header in transmission order, byte 0 in the top bits
  assign hdr_o = {w_ver_tos, total_length_i, ident_i, FlagsFrag, w_ttl_proto, csum,
                  source_address_i, destination_address_i};

endmodule

/* rtl/ipv4_header_builder_core.sv */
// IPv4 header builder.
// Input channel: one request word per header (total length, source and
// destination address, protocol number) on in_valid_i / in_stall_o.
// Output channel: the 20 header bytes in network order on out_valid_o /
// out_stall_i, each word carrying the byte, its index 0..19 and a last flag.
// Identification starts at 1 after reset and advances by one per request,
// wrapping modulo 65536. Checksum is the standard Internet header checksum.
// A request goes through the request register into the header shift register
// before its first byte is shown. Throughput: one byte per cycle while
// out_stall_i is low; the byte serializer is the limit. The request register
// takes the next request while the current header is still going out, and
// the next header follows its predecessor's last byte with no gap.
// Reset clears the identification counter and all valid flags; no word is
// shown until a request arrives. A stall on the output holds the current
// byte; once the request register is also full, in_stall_o is raised.
module ipv4_header_builder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] total_length_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [7:0]  protocol_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  header_byte_o,
  output logic [4:0]  byte_index_o,
  output logic        last_byte_o
);
  import iphb_pkg::*;

  logic        in_acc;
  logic        out_acc;
  logic        load;
  logic [15:0] ident_q, ident_d;
  logic        req_valid_q;
  logic [15:0] req_len_q;
  logic [31:0] req_src_q;
  logic [31:0] req_dst_q;
  logic [7:0]  req_proto_q;
  logic [15:0] req_ident_q;
  hdr_t        hdr_fmt;
  hdr_t        hdr_q;
  logic        out_valid_q;
  logic [IdxW-1:0] idx_q;

  // handshakes
  assign out_acc    = out_valid_q && !out_stall_i;
  assign load       = req_valid_q && (!out_valid_q || (out_acc && idx_q == IdxLast));
  assign in_stall_o = req_valid_q && !load;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ident_d    = ident_q + 16'd1;

  // identification counter and request valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q     <= '0;
      req_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ident_q <= ident_d;
      end
      if (in_acc) begin
        req_valid_q <= 1'b1;
      end else if (load) begin
        req_valid_q <= 1'b0;
      end
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_len_q   <= total_length_i;
      req_src_q   <= source_address_i;
      req_dst_q   <= destination_address_i;
      req_proto_q <= protocol_number_i;
      req_ident_q <= ident_d;
    end
  end

  // header formatting and checksum
  iphb_hdr_fmt u_fmt (
    .total_length_i        (req_len_q),
    .source_address_i      (req_src_q),
    .destination_address_i (req_dst_q),
    .protocol_number_i     (req_proto_q),
    .ident_i               (req_ident_q),
    .hdr_o                 (hdr_fmt)
  );

  // serializer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= IdxFirst;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= IdxFirst;
    end else if (out_acc) begin
      if (idx_q == IdxLast) begin
        out_valid_q <= 1'b0;
      end
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // header shift register, current byte in the top bits
  always_ff @(posedge clk_i) begin
    if (load) begin
      hdr_q <= hdr_fmt;
    end else if (out_acc) begin
      hdr_q <= {hdr_q[HdrBits-9:0], 8'h00};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign header_byte_o = hdr_q[HdrBits-1 -: 8];
  assign byte_index_o  = idx_q;
  assign last_byte_o   = (idx_q == IdxLast);

endmodule

/* rtl/iphb_checker.sv */
module iphb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] header_byte_o,
  input logic [4:0] byte_index_o,
  input logic       last_byte_o
);
  import iphb_pkg::*;

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  // last flag marks exactly the final index
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_byte_o == (byte_index_o == IdxLast)))
    else $error("last flag does not match byte index");

  // a taken byte that is not last is followed by the next index
  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_byte_o) |=>
      (out_valid_o && byte_index_o == $past(byte_index_o) + 5'd1))
    else $error("header bytes not contiguous");

  // a new header starts at index zero
  a_new_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_byte_o) |=> (!out_valid_o || byte_index_o == IdxFirst))
    else $error("header does not start at byte zero");

  // every header opens with version and header length
  a_ver_ihl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_index_o == IdxFirst) |-> header_byte_o == VerIhl)
    else $error("bad version byte");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(header_byte_o) && $stable(byte_index_o)))
    else $error("stalled output word changed");

endmodule

bind ipv4_header_builder_core iphb_checker u_iphb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .header_byte_o (header_byte_o),
  .byte_index_o  (byte_index_o),
  .last_byte_o   (last_byte_o)
);
